@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

@@ hw/rtl/lrupp_pkg.sv @@
// ----------------------------------------------------------------------------
// lrupp_pkg
// Shared types and constants of the LRU page pool.
// ----------------------------------------------------------------------------
`default_nettype none
package lrupp_pkg;
	localparam int POOL_SLOTS = 16;
	localparam int PIN_SLOTS  = 16;
	localparam int PIDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int NIDX_W = (PIN_SLOTS > 1) ? $clog2(PIN_SLOTS) : 1;
	localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		CMD_ACCESS = 2'd0,
		CMD_PIN    = 2'd1,
		CMD_UNPIN  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_MISS     = 3'd1,
		ST_EVICT    = 3'd2,
		ST_REFUSED  = 3'd3,
		ST_PINNED   = 3'd4,
		ST_PINFULL  = 3'd5,
		ST_UNPINNED = 3'd6
	} status_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] key;
	} req_t;
endpackage
`default_nettype wire

@@ hw/rtl/lru_page_pool_with_pinning_top.sv @@
// A request passes through the queue, then the back end's match, apply and output steps.
// The back end takes the next request only once the current result has been taken.
// A 2-entry request queue lets the front accept while a result waits.
// Reset: arst_n clears the queue, pool and pin valid bits; keys need no reset.
// ----------------------------------------------------------------------------
// lru_page_pool_with_pinning_top
// LRU page pool with pin table, request queue in front of a sequential back end.
// ----------------------------------------------------------------------------
`default_nettype none
module lru_page_pool_with_pinning_top import lrupp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] matrix_id,
	input  wire logic [15:0] page_index,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic             writeback_valid,
	output logic [15:0]      evicted_matrix_id,
	output logic [15:0]      evicted_page_index,
	output logic [4:0]       resident_count
);
	logic q_valid, q_pop;
	req_t q_head;

	lrupp_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .command, .matrix_id, .page_index,
		.q_valid, .q_pop, .q_head
	);

	lrupp_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_head, .out_valid, .out_stall,
		.status, .writeback_valid, .evicted_matrix_id, .evicted_page_index,
		.resident_count
	);
endmodule
`default_nettype wire

@@ hw/rtl/lrupp_front.sv @@
// ----------------------------------------------------------------------------
// lrupp_front
// Accepts requests, decodes the command and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lrupp_front import lrupp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  command,
	input  wire logic [15:0] matrix_id,
	input  wire logic [15:0] page_index,
	output logic             q_valid,
	input  wire logic        q_pop,
	output req_t             q_head
);
	req_t       mem_q [QDEPTH];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall = (cnt_q == 2'(QDEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_head   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{cmd: cmd_t'(command), key: {matrix_id, page_index}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	`ASSERT_NEVER(a_no_underflow, clk, arst_n, q_pop && !q_valid, "pop of empty queue")
	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q > 2'(QDEPTH), "queue count overflow")
	`ASSERT_IMPL(a_push_count, clk, arst_n, (push && !q_pop) |=> (cnt_q == $past(cnt_q) + 2'd1), "count missed push")
endmodule
`default_nettype wire

@@ hw/rtl/lrupp_back.sv @@
// ----------------------------------------------------------------------------
// lrupp_back
// Executes queued requests on the recency-ordered pool and the pin table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module lrupp_back import lrupp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	output logic             q_pop,
	input  wire req_t        q_head,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic             writeback_valid,
	output logic [15:0]      evicted_matrix_id,
	output logic [15:0]      evicted_page_index,
	output logic [4:0]       resident_count
);
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_MATCH = 4'b0010,
		S_APPLY = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t state_q;
	logic [31:0] pool_key_q [POOL_SLOTS];
	logic        pool_valid_q [POOL_SLOTS];
	logic [31:0] pin_key_q [PIN_SLOTS];
	logic        pin_valid_q [PIN_SLOTS];
	logic [CNT_W-1:0] cnt_q;
	req_t        req_q;

	// match results, registered in S_MATCH (pooled_pin_q in S_IDLE)
	logic              hit_q, pinhit_q, pinfree_q, evok_q;
	logic [PIDX_W-1:0] hitpos_q, evpos_q;
	logic [NIDX_W-1:0] pinpos_q, freepos_q;
	logic [POOL_SLOTS-1:0] pooled_pin_q;

	logic [POOL_SLOTS-1:0] pool_hit_v, pool_pin_v;
	logic [PIN_SLOTS-1:0]  pin_hit_v, pin_free_v;

	always_comb begin
		for (int i = 0; i < POOL_SLOTS; i++) begin
			pool_hit_v[i] = pool_valid_q[i] && pool_key_q[i] == req_q.key;
			pool_pin_v[i] = 1'b0;
			for (int j = 0; j < PIN_SLOTS; j++) begin
				if (pin_valid_q[j] && pin_key_q[j] == pool_key_q[i]) pool_pin_v[i] = 1'b1;
			end
		end
		for (int j = 0; j < PIN_SLOTS; j++) begin
			pin_hit_v[j]  = pin_valid_q[j] && pin_key_q[j] == req_q.key;
			pin_free_v[j] = !pin_valid_q[j];
		end
	end

	logic              f_hit, f_ev, f_ph, f_pf;
	logic [PIDX_W-1:0] f_hp, f_ep;
	logic [NIDX_W-1:0] f_pp, f_fp;
	always_comb begin
		f_hit = 1'b0; f_hp = '0; f_ev = 1'b0; f_ep = '0;
		f_ph = 1'b0; f_pp = '0; f_pf = 1'b0; f_fp = '0;
		for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
			if (pool_hit_v[i]) begin f_hit = 1'b1; f_hp = PIDX_W'(i); end
			if (pool_valid_q[i] && !pooled_pin_q[i]) begin f_ev = 1'b1; f_ep = PIDX_W'(i); end
		end
		for (int j = PIN_SLOTS - 1; j >= 0; j--) begin
			if (pin_hit_v[j]) begin f_ph = 1'b1; f_pp = NIDX_W'(j); end
			if (pin_free_v[j]) begin f_pf = 1'b1; f_fp = NIDX_W'(j); end
		end
	end

	logic pool_full;
	assign pool_full = (cnt_q == CNT_W'(POOL_SLOTS));
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign out_valid = (state_q == S_OUT);

	// removal position and whether a move/insert happens
	logic              do_rm, do_ins;
	logic [PIDX_W-1:0] rm_pos;
	always_comb begin
		do_rm = 1'b0; do_ins = 1'b0; rm_pos = hitpos_q;
		if (req_q.cmd == CMD_ACCESS) begin
			if (hit_q) begin
				do_rm = 1'b1; do_ins = 1'b1;
			end else if (!pool_full) begin
				do_ins = 1'b1;
			end else if (evok_q) begin
				do_rm = 1'b1; do_ins = 1'b1; rm_pos = evpos_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid) req_q <= q_head;
				pooled_pin_q <= pool_pin_v;
			end
			S_MATCH: begin
				hit_q <= f_hit; hitpos_q <= f_hp;
				evok_q <= f_ev; evpos_q <= f_ep;
				pinhit_q <= f_ph; pinpos_q <= f_pp;
				pinfree_q <= f_pf; freepos_q <= f_fp;
			end
			S_APPLY: begin
				status             <= ST_HIT;
				writeback_valid    <= 1'b0;
				evicted_matrix_id  <= '0;
				evicted_page_index <= '0;
				resident_count     <= 5'(cnt_q);
				case (req_q.cmd)
					CMD_ACCESS: begin
						if (hit_q) status <= ST_HIT;
						else if (!pool_full) begin
							status <= ST_MISS;
							resident_count <= 5'(cnt_q + CNT_W'(1));
						end else if (evok_q) begin
							status <= ST_EVICT;
							writeback_valid <= 1'b1;
							{evicted_matrix_id, evicted_page_index} <= pool_key_q[evpos_q];
						end else status <= ST_REFUSED;
					end
					CMD_PIN: begin
						if (pinhit_q) status <= ST_PINNED;
						else if (pinfree_q) begin
							status <= ST_PINNED;
							pin_key_q[freepos_q] <= req_q.key;
						end else status <= ST_PINFULL;
					end
					CMD_UNPIN: status <= ST_UNPINNED;
					default: status <= ST_HIT;
				endcase
				if (do_rm) begin
					for (int i = 0; i < POOL_SLOTS - 1; i++) begin
						if (PIDX_W'(i) >= rm_pos) pool_key_q[i] <= pool_key_q[i+1];
					end
					pool_key_q[PIDX_W'(cnt_q - CNT_W'(1))] <= req_q.key;
				end else if (do_ins) begin
					pool_key_q[PIDX_W'(cnt_q)] <= req_q.key;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			for (int i = 0; i < POOL_SLOTS; i++) pool_valid_q[i] <= 1'b0;
			for (int j = 0; j < PIN_SLOTS; j++) pin_valid_q[j] <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE:  if (q_valid) state_q <= S_MATCH;
				S_MATCH: state_q <= S_APPLY;
				S_APPLY: begin
					state_q <= S_OUT;
					if (do_ins && !do_rm) begin
						pool_valid_q[PIDX_W'(cnt_q)] <= 1'b1;
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (req_q.cmd == CMD_PIN && !pinhit_q && pinfree_q)
						pin_valid_q[freepos_q] <= 1'b1;
					if (req_q.cmd == CMD_UNPIN && pinhit_q)
						pin_valid_q[pinpos_q] <= 1'b0;
				end
				S_OUT:   if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_NEVER(a_cnt_max, clk, arst_n, cnt_q > CNT_W'(POOL_SLOTS), "pool count overflow")
	`ASSERT_IMPL(a_wb_evict, clk, arst_n, out_valid |-> (writeback_valid == (status == ST_EVICT)), "writeback flag mismatch")
	`ASSERT_IMPL(a_cnt_mono, clk, arst_n, (state_q == S_APPLY && req_q.cmd != CMD_ACCESS) |=> $stable(cnt_q), "count moved on pin")
endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the LRU page pool with pin table. A table of directed
// requests runs first, then random requests drawn from a small key set so
// that hits, evictions, refusals and a full pin table all occur. Every result
// is checked field by field against an in-bench model of the pool.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top import lrupp_pkg::*; ();

	typedef struct packed {
		logic [2:0]  st;
		logic        wb;
		logic [15:0] ev_mid;
		logic [15:0] ev_pidx;
		logic [4:0]  cnt;
	} pool_result_t;

	typedef struct {
		cmd_t         cmd;
		logic [15:0]  mid;
		logic [15:0]  pidx;
		bit           fixed;
		pool_result_t res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] command = '0;
	logic [15:0] matrix_id = '0;
	logic [15:0] page_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic writeback_valid;
	logic [15:0] evicted_matrix_id;
	logic [15:0] evicted_page_index;
	logic [4:0] resident_count;

	always #2 clk = ~clk;

	lru_page_pool_with_pinning_top dut (.*);

	// model state: pool oldest first
	logic [31:0] pool_keys[$];
	logic [31:0] pinned_keys[PIN_SLOTS];
	bit pinned_used[PIN_SLOTS];
	pool_result_t expected_results[$];
	int errors = 0;
	longint cycles = 0;
	bit quiet = 1'b0;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic int find_pin(input logic [31:0] k);
		for (int i = 0; i < PIN_SLOTS; i++)
			if (pinned_used[i] && pinned_keys[i] == k) return i;
		return -1;
	endfunction

	function automatic pool_result_t apply_request(input logic [1:0] c, input logic [31:0] k);
		pool_result_t r;
		int slot;
		bit hit;
		r = '0;
		r.st = ST_HIT;
		hit = 1'b0;
		if (c == CMD_ACCESS) begin
			for (int i = 0; i < pool_keys.size(); i++)
				if (!hit && pool_keys[i] == k) begin
					pool_keys.delete(i);
					pool_keys.insert(pool_keys.size(), k);
					hit = 1'b1;
				end
			if (hit) begin
				r.st = ST_HIT;
			end else if (pool_keys.size() < POOL_SLOTS) begin
				pool_keys.insert(pool_keys.size(), k);
				r.st = ST_MISS;
			end else begin
				r.st = ST_REFUSED;
				for (int i = 0; i < pool_keys.size(); i++)
					if (r.st == ST_REFUSED && find_pin(pool_keys[i]) < 0) begin
						{r.ev_mid, r.ev_pidx} = pool_keys[i];
						pool_keys.delete(i);
						pool_keys.insert(pool_keys.size(), k);
						r.st = ST_EVICT;
						r.wb = 1'b1;
					end
			end
		end else if (c == CMD_PIN) begin
			if (find_pin(k) >= 0) begin
				r.st = ST_PINNED;
			end else begin
				slot = -1;
				for (int j = PIN_SLOTS - 1; j >= 0; j--)
					if (!pinned_used[j]) slot = j;
				if (slot < 0) begin
					r.st = ST_PINFULL;
				end else begin
					pinned_keys[slot] = k;
					pinned_used[slot] = 1'b1;
					r.st = ST_PINNED;
				end
			end
		end else if (c == CMD_UNPIN) begin
			slot = find_pin(k);
			if (slot >= 0) pinned_used[slot] = 1'b0;
			r.st = ST_UNPINNED;
		end
		r.cnt = 5'(pool_keys.size());
		return r;
	endfunction

	task automatic send(input logic [1:0] c, input logic [15:0] m, input logic [15:0] p,
			input bit fixed, input pool_result_t fres);
		pool_result_t r;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		matrix_id <= m;
		page_index <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = apply_request(c, {m, p});
		if (fixed && r != fres) report($sformatf("model vs table row %h", {m, p}));
		expected_results.insert(expected_results.size(), r);
	endtask

	always @(posedge clk) begin
		pool_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report("result with no request pending");
			end else begin
				e = expected_results.pop_front();
				if (status != e.st) report($sformatf("status %0d exp %0d", status, e.st));
				if (writeback_valid != e.wb) report("writeback_valid");
				if (evicted_matrix_id != e.ev_mid) report("evicted_matrix_id");
				if (evicted_page_index != e.ev_pidx) report("evicted_page_index");
				if (resident_count != e.cnt)
					report($sformatf("count %0d exp %0d", resident_count, e.cnt));
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic pool_result_t mk(input status_t s, input int cnt);
		pool_result_t r;
		r = '0;
		r.st = s;
		r.cnt = 5'(cnt);
		return r;
	endfunction

	initial begin
		dir_row_t rows[$];
		logic [1:0] c;
		logic [15:0] m;
		logic [15:0] p;
		int n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, nop, pin table fill and overflow, all pinned refusal
		rows.insert(rows.size(), '{CMD_NOP, 16'hffff, 16'hffff, 1'b1, mk(ST_HIT, 0)});
		rows.insert(rows.size(), '{CMD_UNPIN, 16'h0000, 16'h0000, 1'b1, mk(ST_UNPINNED, 0)});
		rows.insert(rows.size(), '{CMD_ACCESS, 16'h0000, 16'h0000, 1'b1, mk(ST_MISS, 1)});
		rows.insert(rows.size(), '{CMD_ACCESS, 16'hffff, 16'hffff, 1'b1, mk(ST_MISS, 2)});
		rows.insert(rows.size(), '{CMD_ACCESS, 16'h0000, 16'h0000, 1'b1, mk(ST_HIT, 2)});
		rows.insert(rows.size(), '{CMD_PIN, 16'hffff, 16'hffff, 1'b1, mk(ST_PINNED, 2)});
		rows.insert(rows.size(), '{CMD_PIN, 16'hffff, 16'hffff, 1'b1, mk(ST_PINNED, 2)});
		foreach (rows[i]) send(rows[i].cmd, rows[i].mid, rows[i].pidx, rows[i].fixed, rows[i].res);
		// pin 15 more keys, then one too many
		for (int i = 1; i < 16; i++) send(CMD_PIN, 16'h00a0, 16'(i), 1'b0, '0);
		send(CMD_PIN, 16'h5555, 16'haaaa, 1'b1, mk(ST_PINFULL, 2));
		// fill the pool with pinned keys plus the pinned ffff key
		for (int i = 1; i < 16; i++) send(CMD_ACCESS, 16'h00a0, 16'(i), 1'b0, '0);
		send(CMD_ACCESS, 16'h1234, 16'h5678, 1'b0, '0);
		send(CMD_ACCESS, 16'haaaa, 16'h5555, 1'b0, '0);
		// random part over a small key set, with rare wide keys
		for (int i = 0; i < 1000; i++) begin
			if (i >= 900) quiet = 1'b1;
			n = $urandom_range(0, 99);
			c = (n < 60) ? CMD_ACCESS : (n < 78) ? CMD_PIN : (n < 97) ? CMD_UNPIN : CMD_NOP;
			if ($urandom_range(0, 19) == 0) begin
				m = 16'($urandom);
				p = 16'($urandom);
			end else begin
				m = 16'($urandom_range(0, 3) | (($urandom_range(0, 7) == 0) ? 16'hfff0 : 16'h0));
				p = 16'($urandom_range(0, 7) | (($urandom_range(0, 7) == 0) ? 16'hff00 : 16'h0));
			end
			send(c, m, p, 1'b0, '0);
		end
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/lrupp_pkg.sv
hw/rtl/lrupp_front.sv
hw/rtl/lrupp_back.sv
hw/rtl/lru_page_pool_with_pinning_top.sv
tb/sv/tb_top.sv
